### rtl/nbc_pkg.sv
// Shared constants and types for the nested blob counter.
package nbc_pkg;

	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLS    = 64;
	localparam int MAX_REGIONS = 64;

	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int COL_W   = $clog2(MAX_COLS);
	localparam int PIX_W   = ROW_W + COL_W;
	localparam int NPIX    = 1 << PIX_W;
	localparam int STK_DEPTH = 2 * NPIX;
	localparam int SP_W    = $clog2(STK_DEPTH) + 1;
	localparam int REG_AW  = $clog2(MAX_REGIONS);
	localparam int TOT_W   = REG_AW + 1;
	localparam int DIM_W   = 7;
	localparam int CNT_W   = 8;
	localparam int CELL_W  = 4;

	localparam logic [1:0] CLS_BG   = 2'd0;
	localparam logic [1:0] CLS_OBJ  = 2'd1;
	localparam logic [1:0] CLS_SPOT = 2'd2;
	localparam logic [1:0] CLS_RSVD = 2'd3;

	localparam logic [1:0] REG_ROWS = 2'd0;
	localparam logic [1:0] REG_COLS = 2'd1;

	// One stored pixel: class plus the two visit marks.
	typedef struct packed {
		logic       smark;
		logic       rmark;
		logic [1:0] cls;
	} cell_t;

endpackage

### rtl/nested_blob_counter.sv
// Nested blob counter: stores a frame, labels object regions and counts spot blobs in each.
//
//  channel   direction  fields
//  s_axis    in         tdata[1:0] pixel_class
//  m_axis    out        tdata[7:0] spot_count, tlast last_of_frame,
//                       tuser[0] no_regions, tuser[1] region_overflow
//  cfg       in         index 0 row_count, index 1 col_count
//
// Pixels load at one word per cycle into the cell memory. After the last pixel the
// raster scan reads, checks and steps past each pixel; a region pixel and a spot pixel
// each add a stack walk, bounded by the one cell memory port.
// Results come from repeated count scans over the R regions: one scan for
// zero and one for each distinct nonzero count.
// Reset clears all control state; memories need no clearing since loading a pixel
// clears its marks. The input is not ready while a frame is processed; a stalled
// output word holds the count scan.
module nested_blob_counter (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [7:0]               s_axis_tdata,   // [1:0] pixel_class, rest zero
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [7:0]               m_axis_tdata,   // [7:0] spot_count
	output logic                     m_axis_tlast,
	output logic [1:0]               m_axis_tuser,   // [0] no_regions, [1] region_overflow
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [nbc_pkg::DIM_W-1:0] cfg_data
);
	import nbc_pkg::*;

	typedef enum logic [3:0] {
		LOAD, SCAN_RD, SCAN_CHK, SCAN_NEXT,
		R_POP, R_POPW, R_CUR, R_NB, R_NBW,
		S_POP, S_POPW, S_NB, S_NBW,
		EMPTY, E_RD, E_CHK
	} state_t;

	typedef enum logic [1:0] {D_DOWN, D_UP, D_RIGHT, D_LEFT} dir_t;

	state_t state_q;
	dir_t   dir_q;

	logic [DIM_W-1:0] rows_q, cols_q, rows_eff, cols_eff;
	logic [ROW_W-1:0] pos_r_q;
	logic [COL_W-1:0] pos_c_q;
	logic [PIX_W-1:0] rcur_q, scur_q, nb_q;
	logic [SP_W-1:0]  sp_q, base_q;
	logic [CNT_W-1:0] cnt_q, tgt_q;
	logic [CNT_W:0]   nxt_q, nxt_new;
	logic [TOT_W-1:0] total_q, k_q, emitted_q;
	logic             ovf_q;

	logic             m_tvalid_q, m_tlast_q;
	logic [CNT_W-1:0] m_count_q;
	logic [1:0]       m_user_q;

	// Memory ports.
	logic              cell_we;
	logic [PIX_W-1:0]  cell_waddr, cell_raddr;
	cell_t             cell_wdata, cell_rd;
	logic [CELL_W-1:0] cell_rdata;
	logic              stk_we;
	logic [PIX_W-1:0]  stk_wdata, stk_rdata;
	logic [SP_W-2:0]   stk_raddr;
	logic              cnt_we;
	logic [CNT_W-1:0]  cnt_rdata;

	logic             in_acc, col_last, row_last, out_free, out_load, cfg_hit;
	logic             nb_ok;
	logic [ROW_W-1:0] cur_r, nb_r;
	logic [COL_W-1:0] cur_c, nb_c;
	logic             start_region, spot_start, r_push, s_push, match;
	logic [1:0]       in_cls;

	assign rows_eff = (rows_q == '0) ? DIM_W'(1) :
		(rows_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_q;
	assign cols_eff = (cols_q == '0) ? DIM_W'(1) :
		(cols_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_q;

	assign s_axis_tready = (state_q == LOAD);
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign in_cls   = (s_axis_tdata[1:0] == CLS_RSVD) ? CLS_OBJ : s_axis_tdata[1:0];
	assign col_last = (DIM_W'(pos_c_q) + DIM_W'(1)) == cols_eff;
	assign row_last = (DIM_W'(pos_r_q) + DIM_W'(1)) == rows_eff;
	assign out_free = !m_tvalid_q || m_axis_tready;
	assign cell_rd  = cell_t'(cell_rdata);
	assign cfg_hit  = cfg_we && (cfg_index == REG_ROWS || cfg_index == REG_COLS);

	assign start_region = (state_q == SCAN_CHK) && (cell_rd.cls != CLS_BG) && !cell_rd.rmark;
	assign spot_start   = (state_q == R_CUR) && (cell_rd.cls == CLS_SPOT) && !cell_rd.smark;
	assign r_push       = (state_q == R_NBW) && (cell_rd.cls != CLS_BG) && !cell_rd.rmark;
	assign s_push       = (state_q == S_NBW) && (cell_rd.cls == CLS_SPOT) && !cell_rd.smark;

	// Neighbor of the pixel being expanded, in the direction of dir_q.
	always_comb begin
		cur_r = (state_q == R_NB) ? rcur_q[PIX_W-1:COL_W] : scur_q[PIX_W-1:COL_W];
		cur_c = (state_q == R_NB) ? rcur_q[COL_W-1:0] : scur_q[COL_W-1:0];
		nb_r  = cur_r;
		nb_c  = cur_c;
		nb_ok = 1'b0;
		case (dir_q)
			D_DOWN: begin
				nb_r  = cur_r + ROW_W'(1);
				nb_ok = (DIM_W'(cur_r) + DIM_W'(1)) < rows_eff;
			end
			D_UP: begin
				nb_r  = cur_r - ROW_W'(1);
				nb_ok = cur_r != '0;
			end
			D_RIGHT: begin
				nb_c  = cur_c + COL_W'(1);
				nb_ok = (DIM_W'(cur_c) + DIM_W'(1)) < cols_eff;
			end
			D_LEFT: begin
				nb_c  = cur_c - COL_W'(1);
				nb_ok = cur_c != '0;
			end
			default: nb_ok = 1'b0;
		endcase
	end

	always_comb begin
		case (state_q)
			R_POPW:       cell_raddr = stk_rdata;
			R_NB, S_NB:   cell_raddr = {nb_r, nb_c};
			default:      cell_raddr = {pos_r_q, pos_c_q};
		endcase

		cell_we    = 1'b0;
		cell_waddr = {pos_r_q, pos_c_q};
		cell_wdata = cell_rd;
		stk_we     = 1'b0;
		stk_wdata  = nb_q;
		if (in_acc) begin
			cell_we    = 1'b1;
			cell_wdata = '{smark: 1'b0, rmark: 1'b0, cls: in_cls};
		end else if (start_region) begin
			cell_we          = 1'b1;
			cell_wdata.rmark = 1'b1;
			stk_we           = 1'b1;
			stk_wdata        = {pos_r_q, pos_c_q};
		end else if (spot_start) begin
			cell_we          = 1'b1;
			cell_waddr       = rcur_q;
			cell_wdata.smark = 1'b1;
			stk_we           = 1'b1;
			stk_wdata        = rcur_q;
		end else if (r_push) begin
			cell_we          = 1'b1;
			cell_waddr       = nb_q;
			cell_wdata.rmark = 1'b1;
			stk_we           = 1'b1;
		end else if (s_push) begin
			cell_we          = 1'b1;
			cell_waddr       = nb_q;
			cell_wdata.smark = 1'b1;
			stk_we           = 1'b1;
		end
	end

	assign stk_raddr = sp_q[SP_W-2:0] - (SP_W-1)'(1);
	assign cnt_we    = (state_q == R_POP) && (sp_q == '0) && (total_q < TOT_W'(MAX_REGIONS));
	assign match     = cnt_rdata == tgt_q;
	assign nxt_new   = ((cnt_rdata > tgt_q) && ({1'b0, cnt_rdata} < nxt_q)) ?
		{1'b0, cnt_rdata} : nxt_q;
	assign out_load  = out_free && ((state_q == EMPTY) || ((state_q == E_CHK) && match));

	nbc_ram #(.WIDTH(CELL_W), .DEPTH(NPIX)) u_cell_ram (
		.clk(clk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
		.raddr(cell_raddr), .rdata(cell_rdata)
	);

	nbc_ram #(.WIDTH(PIX_W), .DEPTH(STK_DEPTH)) u_stack_ram (
		.clk(clk), .we(stk_we), .waddr(sp_q[SP_W-2:0]), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	nbc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_REGIONS)) u_count_ram (
		.clk(clk), .we(cnt_we), .waddr(total_q[REG_AW-1:0]), .wdata(cnt_q),
		.raddr(k_q[REG_AW-1:0]), .rdata(cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= LOAD;
			dir_q      <= D_DOWN;
			rows_q     <= DIM_W'(MAX_ROWS);
			cols_q     <= DIM_W'(MAX_COLS);
			pos_r_q    <= '0;
			pos_c_q    <= '0;
			sp_q       <= '0;
			base_q     <= '0;
			cnt_q      <= '0;
			tgt_q      <= '0;
			nxt_q      <= '0;
			total_q    <= '0;
			k_q        <= '0;
			emitted_q  <= '0;
			ovf_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
			m_count_q  <= '0;
			m_user_q   <= '0;
			rcur_q     <= '0;
			scur_q     <= '0;
			nb_q       <= '0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_hit) begin
				if (cfg_index == REG_ROWS) begin
					rows_q <= cfg_data;
				end else begin
					cols_q <= cfg_data;
				end
			end
			case (state_q)
				LOAD: begin
					// A register write restarts the frame being loaded.
					if (cfg_hit) begin
						pos_r_q <= '0;
						pos_c_q <= '0;
					end else if (in_acc) begin
						if (col_last) begin
							pos_c_q <= '0;
							if (row_last) begin
								pos_r_q <= '0;
								total_q <= '0;
								ovf_q   <= 1'b0;
								state_q <= SCAN_RD;
							end else begin
								pos_r_q <= pos_r_q + ROW_W'(1);
							end
						end else begin
							pos_c_q <= pos_c_q + COL_W'(1);
						end
					end
				end
				SCAN_RD: state_q <= SCAN_CHK;
				SCAN_CHK: begin
					if (start_region) begin
						sp_q    <= SP_W'(1);
						cnt_q   <= '0;
						state_q <= R_POP;
					end else begin
						state_q <= SCAN_NEXT;
					end
				end
				SCAN_NEXT: begin
					if (col_last) begin
						pos_c_q <= '0;
						if (row_last) begin
							pos_r_q   <= '0;
							k_q       <= '0;
							tgt_q     <= '0;
							nxt_q     <= {1'b1, CNT_W'(0)};
							emitted_q <= '0;
							state_q   <= (total_q == '0) ? EMPTY : E_RD;
						end else begin
							pos_r_q <= pos_r_q + ROW_W'(1);
							state_q <= SCAN_RD;
						end
					end else begin
						pos_c_q <= pos_c_q + COL_W'(1);
						state_q <= SCAN_RD;
					end
				end
				R_POP: begin
					if (sp_q == '0) begin
						if (total_q < TOT_W'(MAX_REGIONS)) begin
							total_q <= total_q + TOT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						state_q <= SCAN_NEXT;
					end else begin
						sp_q    <= sp_q - SP_W'(1);
						state_q <= R_POPW;
					end
				end
				R_POPW: begin
					rcur_q  <= stk_rdata;
					state_q <= R_CUR;
				end
				R_CUR: begin
					dir_q <= D_DOWN;
					if (spot_start) begin
						if (cnt_q != '1) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						base_q  <= sp_q;
						sp_q    <= sp_q + SP_W'(1);
						state_q <= S_POP;
					end else begin
						state_q <= R_NB;
					end
				end
				R_NB, S_NB: begin
					nb_q <= {nb_r, nb_c};
					if (nb_ok) begin
						state_q <= (state_q == R_NB) ? R_NBW : S_NBW;
					end else if (dir_q == D_LEFT) begin
						state_q <= (state_q == R_NB) ? R_POP : S_POP;
					end else begin
						dir_q <= dir_t'(dir_q + 2'd1);
					end
				end
				R_NBW, S_NBW: begin
					if (r_push || s_push) begin
						sp_q <= sp_q + SP_W'(1);
					end
					if (dir_q == D_LEFT) begin
						state_q <= (state_q == R_NBW) ? R_POP : S_POP;
					end else begin
						dir_q   <= dir_t'(dir_q + 2'd1);
						state_q <= (state_q == R_NBW) ? R_NB : S_NB;
					end
				end
				S_POP: begin
					dir_q <= D_DOWN;
					if (sp_q == base_q) begin
						// Spot blob done: resume expanding the region pixel that began it.
						state_q <= R_NB;
					end else begin
						sp_q    <= sp_q - SP_W'(1);
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					scur_q  <= stk_rdata;
					state_q <= S_NB;
				end
				EMPTY: begin
					if (out_free) begin
						m_count_q  <= '0;
						m_tlast_q  <= 1'b1;
						m_user_q   <= 2'b01;
						state_q    <= LOAD;
					end
				end
				E_RD: state_q <= E_CHK;
				E_CHK: begin
					// Each pass emits the entries equal to the target in store order and
					// finds the next larger value for the following pass.
					if (!(match && !out_free)) begin
						if (match) begin
							m_count_q  <= cnt_rdata;
							m_tlast_q  <= (emitted_q + TOT_W'(1)) == total_q;
							m_user_q   <= {ovf_q, 1'b0};
							emitted_q  <= emitted_q + TOT_W'(1);
						end
						if ((k_q + TOT_W'(1)) == total_q) begin
							k_q <= '0;
							if (nxt_new[CNT_W]) begin
								state_q <= LOAD;
							end else begin
								tgt_q   <= nxt_new[CNT_W-1:0];
								nxt_q   <= {1'b1, CNT_W'(0)};
								state_q <= E_RD;
							end
						end else begin
							k_q     <= k_q + TOT_W'(1);
							nxt_q   <= nxt_new;
							state_q <= E_RD;
						end
					end
				end
				default: state_q <= LOAD;
			endcase
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_count_q;
	assign m_axis_tlast  = m_tlast_q;
	assign m_axis_tuser  = m_user_q;

	a_spot_above_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> (sp_q >= base_q))
		else $error("spot walk popped below its base");

	a_last_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == LOAD && m_tvalid_q && m_tlast_q && !m_user_q[0]) |->
		(emitted_q == total_q))
		else $error("last word sent before all regions emitted");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TOT_W'(MAX_REGIONS))
		else $error("region total beyond capacity");

	a_sort_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_CHK) |-> (k_q < total_q))
		else $error("count scan past region total");
endmodule

### rtl/nbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
